FILE: rtl/bsgd_pkg.sv
// Shared types, constants and helpers of the bright-spot grid detector.
// No dependencies; every other file of the block imports this package.
package bsgd_pkg;

  localparam int MAX_FRAME_DIM = 4096;
  localparam int COL_W         = $clog2(MAX_FRAME_DIM);
  localparam int CNT_W         = COL_W + 1;
  localparam int LUMA_W        = 16;
  localparam int STRIDE_W      = 9;
  localparam int PHASE_W       = 8;
  localparam int DIM_W         = 13;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int NUM_SLOTS     = 3;
  localparam int MEM_AW        = 2 + COL_W;

  localparam logic [DIM_W-1:0]    MAX_DIM    = DIM_W'(MAX_FRAME_DIM);
  localparam logic [STRIDE_W-1:0] MAX_STRIDE = STRIDE_W'(256);

  // Luma weights, BT.709 ratios scaled to sum to 65536.
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  // Operation queue depth between the front and the back.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Input action codes.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STRIDE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_THRESH  = 2'd3;

  // One operation for the back end.
  typedef struct packed {
    logic              empty;   // empty-grid frame end
    logic              wr;      // store luma at bank_w/col_w
    logic              win;     // slide the window and maybe report
    logic              first;   // first drain tick, window needs priming
    logic              clr;     // window starts over at this column
    logic [1:0]        bank_w;
    logic [1:0]        bank_m;
    logic [1:0]        bank_a;
    logic [COL_W-1:0]  col_w;
    logic [COL_W-1:0]  col_r;
    logic              ok_m;
    logic              ok_a;
    logic              ok_a0;
    logic              has_b;
    logic              emit0;
    logic              emit1;
    logic              done;
    logic [COL_W-1:0]  x0;
    logic [COL_W-1:0]  x1;
    logic [COL_W-1:0]  y;
    logic [LUMA_W-1:0] luma;
  } bsgd_op_t;

  // One result word.
  typedef struct packed {
    logic              seed_valid;
    logic [COL_W-1:0]  seed_x;
    logic [COL_W-1:0]  seed_y;
    logic [LUMA_W-1:0] strength;
    logic              frame_done;
    logic              last_of_run;
  } bsgd_res_t;

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

FILE: rtl/bsgd_front.sv
// Front end: accepts words, tracks frame and grid position, computes luma
// and issues one operation per grid point or drain tick. Uses bsgd_pkg.
module bsgd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_action,
  input  logic [23:0]                  in_pixel_rgb,
  input  logic [bsgd_pkg::DIM_W-1:0]    cfg_w,
  input  logic [bsgd_pkg::DIM_W-1:0]    cfg_h,
  input  logic [bsgd_pkg::STRIDE_W-1:0] cfg_s,
  output logic                         push,
  output bsgd_pkg::bsgd_op_t           push_op,
  output logic                         busy
);
  import bsgd_pkg::*;

  logic [COL_W-1:0]   pcol_r, pcol_nxt, prow_r, prow_nxt;
  logic [PHASE_W-1:0] cph_r, cph_nxt, rph_r, rph_nxt;
  logic [COL_W-1:0]   dcol_r, dcol_nxt;
  logic [1:0]         slot_r, slot_nxt, rs_r, rs_nxt;
  logic [CNT_W-1:0]   cols_r [NUM_SLOTS];
  logic [CNT_W-1:0]   cols_nxt [NUM_SLOTS];
  logic [COL_W-1:0]   sy_r [NUM_SLOTS];
  logic [COL_W-1:0]   sy_nxt [NUM_SLOTS];
  logic               full_r, full_nxt;

  logic               s1_v_r, s1_v_nxt;
  bsgd_op_t           s1_op_r, s1_op_nxt;
  logic [23:0]        pr_r, pg_r, pb_r;

  logic [DIM_W-1:0]    w, h;
  logic [STRIDE_W-1:0] s;
  logic [PHASE_W-1:0]  off;
  logic                acc, grid_row, done;
  logic [1:0]          p, a;
  logic [CNT_W-1:0]    gxw;
  logic [COL_W-1:0]    gx, xg;
  logic [COL_W+STRIDE_W-1:0] gxs;
  logic [24:0]         sum;

  assign w   = (cfg_w == '0) ? DIM_W'(1) : ((cfg_w > MAX_DIM) ? MAX_DIM : cfg_w);
  assign h   = (cfg_h == '0) ? DIM_W'(1) : ((cfg_h > MAX_DIM) ? MAX_DIM : cfg_h);
  assign s   = (cfg_s == '0) ? STRIDE_W'(1) : ((cfg_s > MAX_STRIDE) ? MAX_STRIDE : cfg_s);
  assign off = s[STRIDE_W-1:1];
  assign acc = in_valid && !in_stall;
  assign busy = s1_v_r;

  always_comb begin
    pcol_nxt = pcol_r; prow_nxt = prow_r; cph_nxt = cph_r; rph_nxt = rph_r;
    dcol_nxt = dcol_r; slot_nxt = slot_r; rs_nxt = rs_r;
    cols_nxt = cols_r; sy_nxt = sy_r; full_nxt = full_r;
    s1_v_nxt = 1'b0; s1_op_nxt = '0;
    grid_row = 1'b0; done = 1'b0; p = 2'd0; a = 2'd0; gxw = '0; gx = '0;
    gxs = '0; xg = '0;
    if (acc) begin
      if (in_action == ACT_DRAIN) begin
        if (full_r) begin
          s1_v_nxt = 1'b1;
          if (rs_r == 2'd0 || cols_r[slot_r] == '0) begin
            s1_op_nxt.empty = 1'b1;
            done = 1'b1;
          end else begin
            gx  = dcol_r;
            // Pixel column of the grid point follows the stride in force now.
            gxs = {{STRIDE_W{1'b0}}, gx} * {{COL_W{1'b0}}, s};
            xg  = COL_W'(off) + gxs[COL_W-1:0];
            a   = slot_dec(slot_r);
            done = ({1'b0, gx} + CNT_W'(1)) >= cols_r[slot_r];
            s1_op_nxt.win    = 1'b1;
            s1_op_nxt.first  = (gx == '0);
            s1_op_nxt.bank_m = slot_r;
            s1_op_nxt.bank_a = a;
            s1_op_nxt.col_r  = gx + COL_W'(1);
            s1_op_nxt.ok_m   = ({1'b0, gx} + CNT_W'(1)) < cols_r[slot_r];
            s1_op_nxt.ok_a   = (rs_r >= 2'd2) && (({1'b0, gx} + CNT_W'(1)) < cols_r[a]);
            s1_op_nxt.ok_a0  = (rs_r >= 2'd2) && (cols_r[a] != '0);
            s1_op_nxt.emit0  = 1'b1;
            s1_op_nxt.done   = done;
            s1_op_nxt.x0     = xg;
            s1_op_nxt.y      = sy_r[slot_r];
            dcol_nxt = gx + COL_W'(1);
          end
          if (done) begin
            pcol_nxt = '0; prow_nxt = '0; cph_nxt = '0; rph_nxt = '0;
            dcol_nxt = '0; rs_nxt = '0; full_nxt = 1'b0;
          end
        end
      end else if (!full_r) begin
        grid_row = (prow_r >= COL_W'(off)) && (rph_r == '0);
        if (grid_row && pcol_r == '0) begin
          slot_nxt = slot_inc(slot_r);
          if (rs_r != 2'd3) begin
            rs_nxt = rs_r + 2'd1;
          end
          cols_nxt[slot_nxt] = '0;
          sy_nxt[slot_nxt]   = prow_r;
        end
        gxw = cols_nxt[slot_nxt];
        gx  = gxw[COL_W-1:0];
        gxs = {{STRIDE_W{1'b0}}, gx} * {{COL_W{1'b0}}, s};
        xg  = COL_W'(off) + gxs[COL_W-1:0];
        p   = slot_dec(slot_nxt);
        a   = slot_inc(slot_nxt);
        if (grid_row && rs_nxt != 2'd0 && pcol_r >= COL_W'(off) && cph_r == '0 &&
            gxw < CNT_W'(MAX_FRAME_DIM)) begin
          cols_nxt[slot_nxt] = gxw + CNT_W'(1);
          s1_v_nxt         = 1'b1;
          s1_op_nxt.wr     = 1'b1;
          s1_op_nxt.bank_w = slot_nxt;
          s1_op_nxt.col_w  = gx;
          if (rs_nxt >= 2'd2) begin
            s1_op_nxt.win    = 1'b1;
            s1_op_nxt.clr    = (gx == '0);
            s1_op_nxt.bank_m = p;
            s1_op_nxt.bank_a = a;
            s1_op_nxt.col_r  = gx;
            s1_op_nxt.ok_m   = {1'b0, gx} < cols_r[p];
            s1_op_nxt.ok_a   = (rs_nxt == 2'd3) && ({1'b0, gx} < cols_r[a]);
            s1_op_nxt.has_b  = 1'b1;
            s1_op_nxt.emit0  = (gx != '0) && (({1'b0, gx} - CNT_W'(1)) < cols_r[p]);
            s1_op_nxt.emit1  = (({1'b0, pcol_r} + CNT_W'(s)) >= w) &&
                               ({1'b0, gx} < cols_r[p]);
            s1_op_nxt.x0     = xg - COL_W'(s);
            s1_op_nxt.x1     = xg;
            s1_op_nxt.y      = sy_r[p];
          end
        end
        if (pcol_r >= COL_W'(off)) begin
          cph_nxt = (({1'b0, cph_r} + STRIDE_W'(1)) >= s) ? '0 : cph_r + PHASE_W'(1);
        end
        if (({1'b0, pcol_r} + DIM_W'(1)) >= w) begin
          pcol_nxt = '0;
          cph_nxt  = '0;
          if (prow_r >= COL_W'(off)) begin
            rph_nxt = (({1'b0, rph_r} + STRIDE_W'(1)) >= s) ? '0 : rph_r + PHASE_W'(1);
          end
          if (({1'b0, prow_r} + DIM_W'(1)) >= h) begin
            full_nxt = 1'b1;
          end else begin
            prow_nxt = prow_r + COL_W'(1);
          end
        end else begin
          pcol_nxt = pcol_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcol_r <= '0; prow_r <= '0; cph_r <= '0; rph_r <= '0;
      dcol_r <= '0; slot_r <= '0; rs_r <= '0; full_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cols_r[i] <= '0;
        sy_r[i]   <= '0;
      end
      s1_v_r <= 1'b0;
    end else begin
      pcol_r <= pcol_nxt; prow_r <= prow_nxt; cph_r <= cph_nxt; rph_r <= rph_nxt;
      dcol_r <= dcol_nxt; slot_r <= slot_nxt; rs_r <= rs_nxt;
      full_r <= full_nxt; cols_r <= cols_nxt; sy_r <= sy_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  // Luma products are registered; the sum is formed on the way into the queue.
  always_ff @(posedge clk) begin
    s1_op_r <= s1_op_nxt;
    pr_r <= {8'd0, W_RED}   * {16'd0, in_pixel_rgb[23:16]};
    pg_r <= {8'd0, W_GREEN} * {16'd0, in_pixel_rgb[15:8]};
    pb_r <= {8'd0, W_BLUE}  * {16'd0, in_pixel_rgb[7:0]};
  end

  assign sum  = {1'b0, pr_r} + {1'b0, pg_r} + {1'b0, pb_r};
  assign push = s1_v_r;

  always_comb begin
    push_op      = s1_op_r;
    push_op.luma = sum[23:8];
  end

endmodule

FILE: rtl/bsgd_queue.sv
// Short operation queue between the front and the back end.
// Depends on bsgd_pkg for the operation type and depth.
module bsgd_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  bsgd_pkg::bsgd_op_t         push_op,
  input  logic                       pop,
  output logic                       q_valid,
  output bsgd_pkg::bsgd_op_t         q_op,
  output logic [bsgd_pkg::QCNT_W-1:0] q_cnt
);
  import bsgd_pkg::*;

  bsgd_op_t           buf_r [QDEPTH];
  logic [QPTR_W-1:0]  wp_r, rp_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_op;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_op    = buf_r[rp_r];
  assign q_cnt   = cnt_r;

endmodule

FILE: rtl/bsgd_back.sv
// Back end: luma row store, 3x3 window over grid columns, verdicts and the
// registered result word. Depends on bsgd_pkg.
module bsgd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bsgd_pkg::LUMA_W-1:0] thr,
  input  logic                       q_valid,
  input  bsgd_pkg::bsgd_op_t         q_op,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bsgd_pkg::bsgd_res_t        out_res
);
  import bsgd_pkg::*;

  logic [LUMA_W-1:0] mem [NUM_SLOTS * MAX_FRAME_DIM];
  logic [LUMA_W-1:0] rdm_r, rda_r;

  logic      primed_r, primed_nxt;
  logic      e_v_r, e_v_nxt, e_clr_r, e_clr_nxt, idx_r, idx_nxt;
  bsgd_op_t  e_op_r, e_op_nxt;
  logic      out_v_r;
  bsgd_res_t out_r;

  // Window: positions 0 and 1 held, position 2 is the fresh column.
  logic [LUMA_W-1:0] wm_r [2], wa_r [2], wb_r [2];
  logic [1:0]        wmok_r, waok_r, wbok_r;

  logic              prime, issue, out_free, has_res, is_last, sel_b, load, e_done;
  logic [COL_W-1:0]  rcol;
  logic [LUMA_W-1:0] m [3], av [3], bv [3];
  logic [2:0]        mok, aok, bok, mok_b, aok_b, bok_b;
  logic              seed_a, seed_b;
  bsgd_res_t         res;

  function automatic logic brighter(input logic [LUMA_W-1:0] v,
                                    input logic [LUMA_W-1:0] x0,
                                    input logic [LUMA_W-1:0] x1,
                                    input logic [LUMA_W-1:0] x2,
                                    input logic [2:0] ok);
    return (ok[0] && x0 > v) || (ok[1] && x1 > v) || (ok[2] && x2 > v);
  endfunction

  assign prime    = q_op.first && !primed_r;
  assign out_free = !out_v_r || !out_stall;
  assign has_res  = e_op_r.empty || e_op_r.emit0 || e_op_r.emit1;
  assign sel_b    = !e_op_r.emit0 || idx_r;
  assign is_last  = e_op_r.empty || sel_b || !e_op_r.emit1;
  assign load     = e_v_r && has_res && out_free;
  assign e_done   = e_v_r && (!has_res || (out_free && is_last));
  assign issue    = q_valid && (!e_v_r || e_done);
  assign pop      = issue && !prime;
  assign rcol     = prime ? '0 : q_op.col_r;

  always_comb begin
    e_op_nxt   = e_op_r;
    e_clr_nxt  = e_clr_r;
    primed_nxt = primed_r;
    e_v_nxt    = e_done ? 1'b0 : e_v_r;
    idx_nxt    = e_done ? 1'b0 : (load ? 1'b1 : idx_r);
    if (issue) begin
      e_v_nxt  = 1'b1;
      e_op_nxt = q_op;
      if (prime) begin
        e_op_nxt.emit0 = 1'b0;
        e_op_nxt.emit1 = 1'b0;
        e_op_nxt.ok_m  = 1'b1;
        e_op_nxt.ok_a  = q_op.ok_a0;
        e_clr_nxt      = 1'b1;
        primed_nxt     = 1'b1;
      end else begin
        e_clr_nxt  = q_op.clr;
        primed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue && q_op.wr && !prime) begin
      mem[{q_op.bank_w, q_op.col_w}] <= q_op.luma;
    end
    if (issue) begin
      rdm_r <= mem[{q_op.bank_m, rcol}];
      rda_r <= mem[{q_op.bank_a, rcol}];
    end
  end

  // Effective 3-column window of the operation in the execute stage.
  always_comb begin
    m[0]  = wm_r[0];  m[1]  = wm_r[1];  m[2]  = rdm_r;
    av[0] = wa_r[0];  av[1] = wa_r[1];  av[2] = rda_r;
    bv[0] = wb_r[0];  bv[1] = wb_r[1];  bv[2] = e_op_r.luma;
    mok = {e_op_r.ok_m,  e_clr_r ? 2'b00 : wmok_r};
    aok = {e_op_r.ok_a,  e_clr_r ? 2'b00 : waok_r};
    bok = {e_op_r.has_b, e_clr_r ? 2'b00 : wbok_r};
    mok_b = {1'b0, mok[2:1]};
    aok_b = {1'b0, aok[2:1]};
    bok_b = {1'b0, bok[2:1]};
    seed_a = (m[1] >= thr) &&
             !brighter(m[1], m[0], m[1], m[2], mok) &&
             !brighter(m[1], av[0], av[1], av[2], aok) &&
             !brighter(m[1], bv[0], bv[1], bv[2], bok);
    seed_b = (m[2] >= thr) &&
             !brighter(m[2], m[1], m[2], '0, mok_b) &&
             !brighter(m[2], av[1], av[2], '0, aok_b) &&
             !brighter(m[2], bv[1], bv[2], '0, bok_b);
    res = '0;
    res.last_of_run = is_last;
    if (e_op_r.empty) begin
      res.frame_done = 1'b1;
    end else if (!sel_b) begin
      res.seed_valid = seed_a;
      res.seed_x     = e_op_r.x0;
      res.seed_y     = e_op_r.y;
      res.strength   = seed_a ? m[1] : '0;
      res.frame_done = e_op_r.done;
    end else begin
      res.seed_valid = seed_b;
      res.seed_x     = e_op_r.x1;
      res.seed_y     = e_op_r.y;
      res.strength   = seed_b ? m[2] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      e_v_r    <= 1'b0;
      e_clr_r  <= 1'b0;
      idx_r    <= 1'b0;
      out_v_r  <= 1'b0;
      wmok_r   <= '0;
      waok_r   <= '0;
      wbok_r   <= '0;
    end else begin
      primed_r <= primed_nxt;
      e_v_r    <= e_v_nxt;
      e_clr_r  <= e_clr_nxt;
      idx_r    <= idx_nxt;
      if (load) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (e_done && e_op_r.win) begin
        wmok_r <= mok[2:1];
        waok_r <= aok[2:1];
        wbok_r <= bok[2:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    e_op_r <= e_op_nxt;
    if (load) begin
      out_r <= res;
    end
    if (e_done && e_op_r.win) begin
      wm_r[0] <= m[1];  wm_r[1] <= m[2];
      wa_r[0] <= av[1]; wa_r[1] <= av[2];
      wb_r[0] <= bv[1]; wb_r[1] <= bv[2];
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

FILE: rtl/bright_spot_grid_detector_unit.sv
// Bright-spot grid detector: thresholded 3x3 non-maximum suppression of luma
// on a sampling grid. An accepted word passes through the luma products, the
// queue, and the store read and execute stage into the output register.
// Throughput is one word per cycle while in_stall is low; the back end takes
// the first drain tick of a frame twice, once to load the window, and a grid
// row's last point yields two results, one per cycle at the output register
// while out_stall is low. Reset (rst_n low, synchronous) clears all control
// state and restores the register defaults; the row store is not cleared.
module bright_spot_grid_detector_unit
  import bsgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [23:0]           in_pixel_rgb,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_seed_valid,
  output logic [COL_W-1:0]      out_seed_x,
  output logic [COL_W-1:0]      out_seed_y,
  output logic [LUMA_W-1:0]     out_strength,
  output logic                  out_frame_done,
  output logic                  out_last_of_run,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  logic [DIM_W-1:0]    width_r, height_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [LUMA_W-1:0]   thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
      stride_r <= STRIDE_W'(8);
      thr_r    <= LUMA_W'(52224);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        REG_GRID_STRIDE:  stride_r <= cfg_wdata[STRIDE_W-1:0];
        REG_LUMA_THRESH:  thr_r    <= cfg_wdata[LUMA_W-1:0];
        default: ;
      endcase
    end
  end

  logic              push, pop, q_valid, busy;
  bsgd_op_t          push_op, q_op;
  logic [QCNT_W-1:0] q_cnt;
  bsgd_res_t         res;

  // The front end only takes a word when the queue is sure to have room for
  // the operation it may create, counting the one still in the luma stage.
  assign in_stall = ({1'b0, q_cnt} + (QCNT_W+1)'(busy)) >= (QCNT_W+1)'(QDEPTH);

  // Front end: position tracking, grid classification and luma.
  bsgd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_pixel_rgb (in_pixel_rgb),
    .cfg_w        (width_r),
    .cfg_h        (height_r),
    .cfg_s        (stride_r),
    .push         (push),
    .push_op      (push_op),
    .busy         (busy)
  );

  // Operation queue decoupling the two halves.
  bsgd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_cnt   (q_cnt)
  );

  // Back end: row store, window, verdicts and the output register.
  bsgd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .thr       (thr_r),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_seed_valid  = res.seed_valid;
  assign out_seed_x      = res.seed_x;
  assign out_seed_y      = res.seed_y;
  assign out_strength    = res.strength;
  assign out_frame_done  = res.frame_done;
  assign out_last_of_run = res.last_of_run;

endmodule

FILE: rtl/bsgd_checker.sv
// Port-level checks of the bright-spot grid detector and their binding.
// Depends on bsgd_pkg and the top level bright_spot_grid_detector_unit.
module bsgd_checker
  import bsgd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  in_action,
  input logic [23:0]           in_pixel_rgb,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_seed_valid,
  input logic [COL_W-1:0]      out_seed_x,
  input logic [COL_W-1:0]      out_seed_y,
  input logic [LUMA_W-1:0]     out_strength,
  input logic                  out_frame_done,
  input logic                  out_last_of_run
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_action) && $stable(in_pixel_rgb))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_seed_valid) && $stable(out_seed_x) &&
      $stable(out_seed_y) && $stable(out_strength) && $stable(out_frame_done) &&
      $stable(out_last_of_run))
    else $error("stalled result word changed");

  a_strength: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_seed_valid |-> out_strength == '0)
    else $error("non-seed result carries a strength");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_run)
    else $error("frame end not marked as last result of its word");

endmodule

bind bright_spot_grid_detector_unit bsgd_checker u_bsgd_checker (.*);
